/* design/ffsa_pkg.sv */
`default_nettype none
package ffsa_pkg;
  localparam int unsigned MaxSegmentsDefault = 16;
  localparam int unsigned AddrBitsDefault = 16;
  localparam int unsigned FieldBits = 16;
  localparam int unsigned KindBits = 3;
  localparam logic [FieldBits-1:0] MemSizeReset = 16'd1024;

  typedef enum logic [KindBits-1:0] {
    KIND_PLACED    = 3'd0,
    KIND_EVICTED   = 3'd1,
    KIND_REMOVED   = 3'd2,
    KIND_NOT_FOUND = 3'd3,
    KIND_TOO_BIG   = 3'd4,
    KIND_FULL      = 3'd5
  } kind_e;

  localparam logic OP_PLACE = 1'b0;
  localparam logic OP_REMOVE = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCAN,
    ST_EVICT,
    ST_SHIFT_UP,
    ST_SHIFT_DOWN,
    ST_WRITE,
    ST_OUT
  } state_e;
endpackage
`default_nettype wire

/* design/ffsa_if.sv */
`default_nettype none
interface ffsa_req_if;
  logic        valid;
  logic        ready;
  logic        op;
  logic [15:0] req_id;
  logic [15:0] req_size;
  modport source (output valid, op, req_id, req_size, input ready);
  modport sink (input valid, op, req_id, req_size, output ready);
endinterface

interface ffsa_rsp_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [15:0] out_id;
  logic [15:0] out_base;
  logic [15:0] out_size;
  logic        last;
  modport source (output valid, kind, out_id, out_base, out_size, last, input ready);
  modport sink (input valid, kind, out_id, out_base, out_size, last, output ready);
endinterface

interface ffsa_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface
`default_nettype wire

/* design/first_fit_segment_allocator_core.sv */
// Channel   Direction  Payload
// req       in         op, req_id, req_size
// rsp       out        kind, out_id, out_base, out_size, last
// cfg       in         memory_size write data
// One request at a time. The table lives in a memory with registered reads;
// a scan reads one entry per cycle. Reset empties the table at once through a
// fill count. A waiting result stalls the sequencer until it is taken.
`default_nettype none
module first_fit_segment_allocator_core #(
  parameter int unsigned MAX_SEGMENTS = ffsa_pkg::MaxSegmentsDefault,
  parameter int unsigned ADDR_BITS = ffsa_pkg::AddrBitsDefault
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  ffsa_req_if.sink   req,
  ffsa_rsp_if.source rsp,
  ffsa_cfg_if.sink   cfg
);
  localparam int unsigned IdxW = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
  localparam int unsigned CntW = $clog2(MAX_SEGMENTS + 1);
  localparam int unsigned EntW = 2 * ffsa_pkg::FieldBits + ADDR_BITS;
  localparam int unsigned SumW = ADDR_BITS + 1;

  typedef struct packed {
    logic [ffsa_pkg::FieldBits-1:0] id;
    logic [ADDR_BITS-1:0]           base;
    logic [ffsa_pkg::FieldBits-1:0] len;
  } entry_t;

  entry_t mem_q [MAX_SEGMENTS];
  entry_t rdata_q;
  logic [IdxW-1:0] raddr;
  logic            we;
  logic [IdxW-1:0] waddr;
  entry_t          wdata;

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[waddr] <= wdata;
    end
    rdata_q <= mem_q[raddr];
  end

  ffsa_pkg::state_e state_q, state_d;
  logic [CntW-1:0] n_q, n_d;
  logic [CntW-1:0] i_q, i_d;
  logic [CntW-1:0] pos_q, pos_d;
  logic            op_q, op_d;
  logic [15:0]     id_q, id_d, size_q, size_d;
  logic [15:0]     msize_q, msize_d;
  logic            prim_q, prim_d;
  logic [SumW-1:0] end_q, end_d;
  logic            place_q, place_d;
  logic [2:0]      okind_q, okind_d;
  logic [15:0]     oid_q, oid_d, obase_q, obase_d, osize_q, osize_d;
  logic            olast_q, olast_d;
  logic            ovalid_q, ovalid_d;
  ffsa_pkg::state_e after_q, after_d;

  logic [SumW-1:0] rd_end;
  logic [SumW-1:0] next_addr;
  logic [SumW-1:0] gap;

  assign rd_end = SumW'(rdata_q.base) + SumW'(rdata_q.len);

  assign cfg.ready = (state_q == ffsa_pkg::ST_IDLE) && !ovalid_q;
  assign req.ready = (state_q == ffsa_pkg::ST_IDLE) && !ovalid_q;
  assign rsp.valid = ovalid_q;
  assign rsp.kind = okind_q;
  assign rsp.out_id = oid_q;
  assign rsp.out_base = obase_q;
  assign rsp.out_size = osize_q;
  assign rsp.last = olast_q;

  always_comb begin
    next_addr = (i_q < n_q) ? SumW'(rdata_q.base) : SumW'(msize_q);
    gap = (next_addr > end_q) ? next_addr - end_q : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ffsa_pkg::ST_IDLE;
      after_q <= ffsa_pkg::ST_IDLE;
      n_q <= '0;
      msize_q <= ffsa_pkg::MemSizeReset;
      ovalid_q <= 1'b0;
      place_q <= 1'b0;
    end else begin
      state_q <= state_d;
      after_q <= after_d;
      n_q <= n_d;
      msize_q <= msize_d;
      ovalid_q <= ovalid_d;
      place_q <= place_d;
    end
  end

  always_ff @(posedge clk_i) begin
    i_q <= i_d;
    pos_q <= pos_d;
    op_q <= op_d;
    id_q <= id_d;
    size_q <= size_d;
    prim_q <= prim_d;
    end_q <= end_d;
    okind_q <= okind_d;
    oid_q <= oid_d;
    obase_q <= obase_d;
    osize_q <= osize_d;
    olast_q <= olast_d;
  end

  always_comb begin
    state_d = state_q;
    after_d = after_q;
    n_d = n_q;
    i_d = i_q;
    pos_d = pos_q;
    op_d = op_q;
    id_d = id_q;
    size_d = size_q;
    prim_d = prim_q;
    end_d = end_q;
    place_d = place_q;
    okind_d = okind_q;
    oid_d = oid_q;
    obase_d = obase_q;
    osize_d = osize_q;
    olast_d = olast_q;
    ovalid_d = ovalid_q;
    msize_d = msize_q;
    raddr = IdxW'(0);
    we = 1'b0;
    waddr = IdxW'(0);
    wdata = '{id: id_q, base: end_q[ADDR_BITS-1:0], len: size_q};

    if (ovalid_q && rsp.ready) begin
      ovalid_d = 1'b0;
    end

    case (state_q)
      ffsa_pkg::ST_IDLE: begin
        if (cfg.valid && cfg.ready) begin
          msize_d = cfg.data;
        end else if (req.valid && req.ready) begin
          op_d = req.op;
          id_d = req.req_id;
          size_d = req.req_size;
          i_d = '0;
          prim_d = 1'b1;
          end_d = '0;
          raddr = IdxW'(0);
          if (req.op == ffsa_pkg::OP_REMOVE) begin
            if (n_q == '0) begin
              okind_d = ffsa_pkg::KIND_NOT_FOUND;
              oid_d = req.req_id; obase_d = '0; osize_d = '0; olast_d = 1'b1;
              ovalid_d = 1'b1;
            end else begin
              state_d = ffsa_pkg::ST_SCAN;
            end
          end else if (req.req_size > msize_q) begin
            okind_d = ffsa_pkg::KIND_TOO_BIG;
            oid_d = req.req_id; obase_d = '0; osize_d = req.req_size; olast_d = 1'b1;
            ovalid_d = 1'b1;
          end else if (n_q >= CntW'(MAX_SEGMENTS)) begin
            okind_d = ffsa_pkg::KIND_FULL;
            oid_d = req.req_id; obase_d = '0; osize_d = req.req_size; olast_d = 1'b1;
            ovalid_d = 1'b1;
          end else if (n_q == '0) begin
            pos_d = '0;
            end_d = '0;
            state_d = ffsa_pkg::ST_WRITE;
          end else begin
            state_d = ffsa_pkg::ST_SCAN;
          end
        end
      end
      ffsa_pkg::ST_SCAN: begin
        // rdata_q holds entry i_q when i_q < n_q; prim_q marks the first cycle.
        if (op_q == ffsa_pkg::OP_REMOVE) begin
          if (rdata_q.id == id_q) begin
            okind_d = ffsa_pkg::KIND_REMOVED;
            oid_d = id_q;
            obase_d = 16'(rdata_q.base);
            osize_d = rdata_q.len;
            olast_d = 1'b1;
            pos_d = i_q;
            after_d = ffsa_pkg::ST_SHIFT_DOWN;
            state_d = ffsa_pkg::ST_OUT;
          end else if (i_q + 1'b1 >= n_q) begin
            okind_d = ffsa_pkg::KIND_NOT_FOUND;
            oid_d = id_q; obase_d = '0; osize_d = '0; olast_d = 1'b1;
            after_d = ffsa_pkg::ST_IDLE;
            state_d = ffsa_pkg::ST_OUT;
          end else begin
            i_d = i_q + 1'b1;
            raddr = IdxW'(i_q + 1'b1);
          end
        end else if (prim_q) begin
          prim_d = 1'b0;
          end_d = rd_end;
          i_d = i_q + 1'b1;
          raddr = IdxW'(i_q + 1'b1);
        end else begin
          if (gap >= SumW'(size_q)) begin
            pos_d = i_q;
            if (i_q == n_q) begin
              state_d = ffsa_pkg::ST_WRITE;
            end else begin
              i_d = n_q;
              state_d = ffsa_pkg::ST_SHIFT_UP;
              raddr = IdxW'(n_q - 1'b1);
            end
          end else if (i_q >= n_q) begin
            end_d = '0;
            pos_d = '0;
            raddr = IdxW'(0);
            state_d = ffsa_pkg::ST_EVICT;
          end else begin
            end_d = rd_end;
            i_d = i_q + 1'b1;
            raddr = IdxW'(i_q + 1'b1);
          end
        end
      end
      ffsa_pkg::ST_EVICT: begin
        // rdata_q holds entry pos_q, the lowest not yet evicted.
        if (pos_q < n_q && rdata_q.base < ADDR_BITS'(size_q)) begin
          if (ovalid_q && !rsp.ready) begin
            // The previous eviction is still waiting; keep the entry in view.
            raddr = IdxW'(pos_q);
          end else begin
            okind_d = ffsa_pkg::KIND_EVICTED;
            oid_d = rdata_q.id;
            obase_d = 16'(rdata_q.base);
            osize_d = rdata_q.len;
            olast_d = 1'b0;
            pos_d = pos_q + 1'b1;
            after_d = ffsa_pkg::ST_EVICT;
            raddr = IdxW'(pos_q + 1'b1);
            state_d = ffsa_pkg::ST_OUT;
          end
        end else begin
          // Drop the evicted prefix, then insert at the front.
          end_d = '0;
          if (pos_q == '0) begin
            if (n_q == '0) begin
              state_d = ffsa_pkg::ST_WRITE;
            end else begin
              i_d = n_q;
              state_d = ffsa_pkg::ST_SHIFT_UP;
              raddr = IdxW'(n_q - 1'b1);
            end
          end else begin
            // Entry 0 is overwritten by the new one; the entries after the prefix shift down.
            n_d = n_q - pos_q + 1'b1;
            i_d = '0;
            pos_d = pos_q - 1'b1;
            place_d = 1'b1;
            raddr = IdxW'(pos_q);
            state_d = (pos_q == 1'b1) ? ffsa_pkg::ST_WRITE : ffsa_pkg::ST_SHIFT_DOWN;
            if (pos_q == 1'b1) begin
              pos_d = '0;
              n_d = n_q;
            end
          end
        end
      end
      ffsa_pkg::ST_SHIFT_UP: begin
        // rdata_q holds entry i_q-1; move it to i_q.
        we = 1'b1;
        waddr = IdxW'(i_q);
        wdata = rdata_q;
        i_d = i_q - 1'b1;
        raddr = IdxW'(i_q - 2'd2);
        if (i_q - 1'b1 == pos_q) begin
          n_d = n_q;
          state_d = ffsa_pkg::ST_WRITE;
        end
      end
      ffsa_pkg::ST_WRITE: begin
        // Wait until the last eviction result has been taken.
        if (!ovalid_q || rsp.ready) begin
          we = 1'b1;
          waddr = IdxW'(place_q ? '0 : pos_q);
          wdata = '{id: id_q, base: end_q[ADDR_BITS-1:0], len: size_q};
          if (place_q) begin
            place_d = 1'b0;
          end else begin
            n_d = n_q + 1'b1;
          end
          okind_d = ffsa_pkg::KIND_PLACED;
          oid_d = id_q;
          obase_d = 16'(end_q);
          osize_d = size_q;
          olast_d = 1'b1;
          after_d = ffsa_pkg::ST_IDLE;
          state_d = ffsa_pkg::ST_OUT;
        end
      end
      ffsa_pkg::ST_SHIFT_DOWN: begin
        if (place_q) begin
          // Compact evicted prefix: move entry i_q+pos_q+1 to i_q+1.
          raddr = IdxW'(i_q + pos_q + 2'd2);
          we = 1'b1;
          waddr = IdxW'(i_q + 1'b1);
          wdata = rdata_q;
          i_d = i_q + 1'b1;
          if (i_q + 2'd2 >= n_q) begin
            pos_d = '0;
            state_d = ffsa_pkg::ST_WRITE;
          end
        end else begin
          // Remove entry pos_q: rdata_q holds entry i_q+1 once primed.
          if (prim_q) begin
            prim_d = 1'b0;
            i_d = pos_q;
            raddr = IdxW'(pos_q + 1'b1);
            if (pos_q + 1'b1 >= n_q) begin
              n_d = n_q - 1'b1;
              state_d = ffsa_pkg::ST_IDLE;
            end
          end else begin
            we = 1'b1;
            waddr = IdxW'(i_q);
            wdata = rdata_q;
            i_d = i_q + 1'b1;
            raddr = IdxW'(i_q + 2'd2);
            if (i_q + 2'd2 >= n_q) begin
              n_d = n_q - 1'b1;
              state_d = ffsa_pkg::ST_IDLE;
            end
          end
        end
      end
      ffsa_pkg::ST_OUT: begin
        raddr = IdxW'(pos_q);
        if (!ovalid_q) begin
          ovalid_d = 1'b1;
          prim_d = 1'b1;
          state_d = after_q;
        end
      end
      default: state_d = ffsa_pkg::ST_IDLE;
    endcase
  end

  // The eviction state always re-reads the entry at pos_q after a result.
  // After ST_OUT with after_q == ST_EVICT the read address was pos_q.

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    n_q <= CntW'(MAX_SEGMENTS)) else $error("segment count overflow");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req.valid && req.ready) |-> !rsp.valid) else $error("request taken with result pending");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ffsa_pkg::ST_WRITE && (!rsp.valid || rsp.ready))
    |=> (state_q == ffsa_pkg::ST_OUT))
    else $error("placement not reported");
endmodule
`default_nettype wire
